// File: src/vnorm_pkg.sv
// Shared constants for the vector normalise block.
// No dependencies; used by the back and top-level modules.
package vnorm_pkg;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned QUOT_W  = 15;
  localparam int unsigned MIN_W   = 16;
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 2;
endpackage

// File: src/vector3_normalize_top.sv
// Vector normalise: one word per cycle; the path runs through
// three input stages, one square-root stage per length bit, the middle queue,
// one setup and fifteen quotient stages, and the result queue.
// Throughput is one word per cycle whenever pop keeps up.
// Synchronous active-high reset empties both queues and clears min_length to 0.
module vector3_normalize_top #(
  parameter int unsigned COMP_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [COMP_WIDTH-1:0] vec_x,
  input  logic signed [COMP_WIDTH-1:0] vec_y,
  input  logic signed [COMP_WIDTH-1:0] vec_z,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [15:0]          unit_x,
  output logic signed [15:0]          unit_y,
  output logic signed [15:0]          unit_z,
  output logic [15:0]                 vec_length,
  output logic                        is_zero,
  input  logic                        min_length_we,
  input  logic [15:0]                 min_length_wdata
);
  localparam int unsigned MW = 4 * COMP_WIDTH + 3;
  localparam int unsigned OD = 4 * vnorm_pkg::OUT_W + 1;

  logic [vnorm_pkg::MIN_W-1:0] min_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (min_length_we) begin
      min_length <= min_length_wdata;
    end
  end

  logic          mq_push;
  logic          mq_full;
  logic [MW-1:0] mq_din;
  logic          mq_pop;
  logic          mq_empty;
  logic [MW-1:0] mq_dout;
  logic          oq_push;
  logic          oq_full;
  logic [OD-1:0] oq_din;
  logic [OD-1:0] oq_dout;

  vnorm_front #(.W(COMP_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .vec_x  (vec_x),
    .vec_y  (vec_y),
    .vec_z  (vec_z),
    .full   (full),
    .q_full (mq_full),
    .q_push (mq_push),
    .q_data (mq_din)
  );

  vnorm_fifo #(.WIDTH(MW), .DEPTH(vnorm_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .din   (mq_din),
    .full  (mq_full),
    .pop   (mq_pop),
    .dout  (mq_dout),
    .empty (mq_empty)
  );

  vnorm_back #(.W(COMP_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (mq_empty),
    .q_data     (mq_dout),
    .q_pop      (mq_pop),
    .min_length (min_length),
    .o_full     (oq_full),
    .o_push     (oq_push),
    .o_data     (oq_din)
  );

  vnorm_fifo #(.WIDTH(OD), .DEPTH(vnorm_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (oq_dout),
    .empty (empty)
  );

  assign unit_x     = oq_dout[64:49];
  assign unit_y     = oq_dout[48:33];
  assign unit_z     = oq_dout[32:17];
  assign vec_length = oq_dout[16:1];
  assign is_zero    = oq_dout[0];
endmodule

// File: src/vnorm_fifo.sv
// Small first-in first-out queue built from flip-flops.
// No dependencies; used between the front and back and at the result side.
module vnorm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end
endmodule

// File: src/vnorm_front.sv
// Front pipeline: magnitudes, squares, sum and a one-bit-per-stage square root.
// Depends on nothing but its parameter; feeds the middle queue.
module vnorm_front #(
  parameter int unsigned W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     vec_x,
  input  logic [W-1:0]     vec_y,
  input  logic [W-1:0]     vec_z,
  output logic             full,
  input  logic             q_full,
  output logic             q_push,
  output logic [4*W+2:0]   q_data
);
  localparam int unsigned SW = 2 * W;
  localparam int unsigned RW = W + 2;

  logic en;

  logic         v_a;
  logic [W-1:0] mag_a [0:2];
  logic [2:0]   neg_a;
  logic         v_b;
  logic [SW-1:0] sq_b [0:2];
  logic [W-1:0] mag_b [0:2];
  logic [2:0]   neg_b;
  logic         v_c;
  logic [SW-1:0] sum_c;
  logic [W-1:0] mag_c [0:2];
  logic [2:0]   neg_c;

  logic          v_s   [1:W];
  logic [RW-1:0] rem_s [1:W];
  logic [W-1:0]  root_s [1:W];
  logic [SW-1:0] rad_s [1:W];
  logic [3*W-1:0] mag_s [1:W];
  logic [2:0]    neg_s [1:W];

  logic [W-1:0] comp_in [0:2];

  assign comp_in[0] = vec_x;
  assign comp_in[1] = vec_y;
  assign comp_in[2] = vec_z;

  assign en     = !(v_s[W] && q_full);
  assign full   = !en;
  assign q_push = v_s[W] && en;
  assign q_data = {mag_s[W], neg_s[W], root_s[W]};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= comp_in[i][W-1];
        mag_a[i] <= comp_in[i][W-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
        sq_b[i]  <= SW'(mag_a[i]) * SW'(mag_a[i]);
        mag_b[i] <= mag_a[i];
        mag_c[i] <= mag_b[i];
      end
      neg_b <= neg_a;
      neg_c <= neg_b;
      sum_c <= sq_b[0] + sq_b[1] + sq_b[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else if (en) begin
      v_a <= push;
      v_b <= v_a;
      v_c <= v_b;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_root
    logic          p_v;
    logic [RW-1:0] p_rem;
    logic [W-1:0]  p_root;
    logic [SW-1:0] p_rad;
    logic [3*W-1:0] p_mag;
    logic [2:0]    p_neg;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          take;

    if (k == 1) begin : g_first
      assign p_v    = v_c;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = sum_c;
      assign p_mag  = {mag_c[0], mag_c[1], mag_c[2]};
      assign p_neg  = neg_c;
    end else begin : g_rest
      assign p_v    = v_s[k-1];
      assign p_rem  = rem_s[k-1];
      assign p_root = root_s[k-1];
      assign p_rad  = rad_s[k-1];
      assign p_mag  = mag_s[k-1];
      assign p_neg  = neg_s[k-1];
    end

    assign cur   = {p_rem, p_rad[SW-1:SW-2]};
    assign trial = (RW+2)'({p_root, 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k]  <= take ? RW'(cur - trial) : RW'(cur);
        root_s[k] <= {p_root[W-2:0], take};
        rad_s[k]  <= {p_rad[SW-3:0], 2'b00};
        mag_s[k]  <= p_mag;
        neg_s[k]  <= p_neg;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= p_v;
      end
    end
  end
endmodule

// File: src/vnorm_back.sv
// Back pipeline: length test and three rounded divisions, one quotient bit per stage.
// Depends on vnorm_pkg; drains the middle queue into the result queue.
module vnorm_back #(
  parameter int unsigned W = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [4*W+2:0]              q_data,
  output logic                        q_pop,
  input  logic [vnorm_pkg::MIN_W-1:0] min_length,
  input  logic                        o_full,
  output logic                        o_push,
  output logic [4*vnorm_pkg::OUT_W:0] o_data
);
  localparam int unsigned QW  = vnorm_pkg::QUOT_W;
  localparam int unsigned FW  = vnorm_pkg::FRAC_W;
  localparam int unsigned OW  = vnorm_pkg::OUT_W;
  localparam int unsigned NW  = W + FW + 1;
  localparam int unsigned DW  = W + 1;
  localparam int unsigned RW  = W + 2;
  localparam int unsigned CW  = (W > vnorm_pkg::MIN_W) ? W : vnorm_pkg::MIN_W;

  logic en;

  logic [W-1:0] in_mag [0:2];
  logic [2:0]   in_neg;
  logic [W-1:0] in_len;

  assign in_mag[0] = q_data[4*W+2:3*W+3];
  assign in_mag[1] = q_data[3*W+2:2*W+3];
  assign in_mag[2] = q_data[2*W+2:W+3];
  assign in_neg    = q_data[W+2:W];
  assign in_len    = q_data[W-1:0];

  logic          v_s    [0:QW];
  logic [RW-1:0] rem_s  [0:QW][0:2];
  logic [QW-1:0] quo_s  [0:QW][0:2];
  logic [FW-1:0] low_s  [0:QW][0:2];
  logic [DW-1:0] div_s  [0:QW];
  logic [2:0]    neg_s  [0:QW];
  logic          zero_s [0:QW];
  logic [W-1:0]  len_s  [0:QW];

  assign en    = !(v_s[QW] && o_full);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [NW-1:0] num;
        num = {1'b0, in_mag[i], {FW{1'b0}}} + NW'(in_len);
        rem_s[0][i] <= RW'(num[NW-1:FW]);
        low_s[0][i] <= num[FW-1:0];
        quo_s[0][i] <= '0;
      end
      div_s[0]  <= {in_len, 1'b0};
      neg_s[0]  <= in_neg;
      zero_s[0] <= (CW'(in_len) <= CW'(min_length));
      len_s[0]  <= in_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= q_pop;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          logic [RW-1:0] cur;
          logic          take;
          cur  = {rem_s[k-1][i][RW-2:0], low_s[k-1][i][FW-1]};
          take = (cur >= RW'(div_s[k-1]));
          rem_s[k][i] <= take ? (cur - RW'(div_s[k-1])) : cur;
          quo_s[k][i] <= {quo_s[k-1][i][QW-2:0], take};
          low_s[k][i] <= {low_s[k-1][i][FW-2:0], 1'b0};
        end
        div_s[k]  <= div_s[k-1];
        neg_s[k]  <= neg_s[k-1];
        zero_s[k] <= zero_s[k-1];
        len_s[k]  <= len_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k] <= 1'b0;
      end else if (en) begin
        v_s[k] <= v_s[k-1];
      end
    end
  end

  logic [OW-1:0] unit [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [OW-1:0] uq;
      uq = OW'(quo_s[QW][i]);
      if (zero_s[QW]) begin
        unit[i] = '0;
      end else if (neg_s[QW][i]) begin
        unit[i] = ~uq + 1'b1;
      end else begin
        unit[i] = uq;
      end
    end
  end

  assign o_push = v_s[QW] && en;
  assign o_data = {unit[0], unit[1], unit[2], OW'(len_s[QW]), zero_s[QW]};
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for vector3_normalize_top: directed and random words,
// predicted in-bench and compared field by field. Depends on the RTL only.
module tb_top;
  localparam int unsigned CW = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_word_t;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic [15:0] len;
    logic zflag;
  } unit_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [15:0] unit_x, unit_y, unit_z;
  logic [15:0] vec_length;
  logic is_zero;
  logic min_length_we = 1'b0;
  logic [15:0] min_length_wdata = '0;

  vec_word_t pending_vecs[$];
  unit_word_t expected_units[$];
  logic [15:0] min_len_model = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  bit send_pause = 1'b0;
  int errors = 0;
  int cycles = 0;
  bit cur_valid = 1'b0;
  bit in_taken = 1'b0;
  vec_word_t cur_vec;

  vector3_normalize_top #(.COMP_WIDTH(CW)) uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .empty(empty), .pop(pop),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .vec_length(vec_length), .is_zero(is_zero),
    .min_length_we(min_length_we), .min_length_wdata(min_length_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem, root, bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[15:0];
  endfunction

  function automatic logic [15:0] scaled_component(input logic signed [CW-1:0] c,
                                                   input logic [63:0] len);
    logic [63:0] mag, q;
    mag = c[CW-1] ? 64'(-$signed(65'(c))) : 64'(c);
    q = ((mag << 15) + len) / (len << 1);
    if (c[CW-1]) q = -q;
    return q[15:0];
  endfunction

  function automatic unit_word_t normalise_vec(input vec_word_t v);
    unit_word_t r;
    logic signed [63:0] sx, sy, sz;
    logic [63:0] sum, len;
    sx = 64'(v.x);
    sy = 64'(v.y);
    sz = 64'(v.z);
    sum = sx * sx + sy * sy + sz * sz;
    len = 64'(floor_sqrt(sum));
    r.len = len[15:0];
    if (len > 64'(min_len_model)) begin
      r.ux = scaled_component(v.x, len);
      r.uy = scaled_component(v.y, len);
      r.uz = scaled_component(v.z, len);
      r.zflag = 1'b0;
    end else begin
      r.ux = '0;
      r.uy = '0;
      r.uz = '0;
      r.zflag = 1'b1;
    end
    return r;
  endfunction

  // Driver: holds the current word until it is taken, then loads the next one.
  always @(negedge clk) begin
    if (cur_valid && in_taken) cur_valid = 1'b0;
    if (!cur_valid && pending_vecs.size() > 0 && !rst && !send_pause
        && $urandom_range(99) >= send_idle_pct) begin
      cur_vec = pending_vecs.pop_front();
      cur_valid = 1'b1;
    end
    push <= cur_valid;
    if (cur_valid) begin
      vec_x <= cur_vec.x;
      vec_y <= cur_vec.y;
      vec_z <= cur_vec.z;
    end
  end

  // Receiver: counts down a long hold-off, otherwise pops at random.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on acceptance, checks each popped word.
  always @(posedge clk) begin
    unit_word_t e;
    cycles <= cycles + 1;
    in_taken <= !rst && push && !full;
    if (!rst && push && !full) expected_units.push_back(normalise_vec({vec_x, vec_y, vec_z}));
    if (!rst && pop && !empty) begin
      if (expected_units.size() == 0) begin
        $error("unexpected word: unit_x %0d", unit_x);
        errors <= errors + 1;
      end else begin
        e = expected_units.pop_front();
        if (unit_x !== e.ux) begin
          $error("unit_x expected %0d got %0d", e.ux, unit_x); errors <= errors + 1;
        end
        if (unit_y !== e.uy) begin
          $error("unit_y expected %0d got %0d", e.uy, unit_y); errors <= errors + 1;
        end
        if (unit_z !== e.uz) begin
          $error("unit_z expected %0d got %0d", e.uz, unit_z); errors <= errors + 1;
        end
        if (vec_length !== e.len) begin
          $error("vec_length expected %0d got %0d", e.len, vec_length);
          errors <= errors + 1;
        end
        if (is_zero !== e.zflag) begin
          $error("is_zero expected %0d got %0d", e.zflag, is_zero); errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain_all();
    while (pending_vecs.size() > 0 || cur_valid || expected_units.size() > 0)
      @(posedge clk);
    repeat (CW + 30) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [15:0] val);
    @(negedge clk);
    min_length_we <= 1'b1;
    min_length_wdata <= val;
    @(negedge clk);
    min_length_we <= 1'b0;
    min_len_model = val;
  endtask

  task automatic queue_vec(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
    vec_word_t v;
    v.x = a;
    v.y = b;
    v.z = c;
    pending_vecs.push_back(v);
  endtask

  task automatic queue_random(input int n);
    logic [15:0] a, b, c;
    int lim;
    for (int i = 0; i < n; i++) begin
      // Mix full-range values with short vectors near the threshold.
      lim = ($urandom_range(3) == 0) ? 255 : 65535;
      a = 16'($urandom_range(lim));
      b = 16'($urandom_range(lim));
      c = 16'($urandom_range(lim));
      if (lim == 255) begin
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(1)) b = -b;
        if ($urandom_range(1)) c = -c;
      end
      queue_vec(a, b, c);
    end
  endtask

  initial begin
    logic [15:0] settings[5];
    int mode[4][2];
    settings = '{16'd0, 16'd4096, 16'd100, 16'd65535, 16'd1};
    mode = '{'{0, 0}, '{55, 0}, '{0, 55}, '{19, 19}};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_vec(16'h0000, 16'h0000, 16'h0000);
    queue_vec(16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_vec(16'h8000, 16'h8000, 16'h8000);
    queue_vec(16'h8000, 16'h0000, 16'h0000);
    queue_vec(16'h7FFF, 16'h0000, 16'h0000);
    queue_vec(16'h0000, 16'hFFFF, 16'h0000);
    queue_vec(16'h0000, 16'h0000, 16'h0001);
    queue_vec(16'h1000, 16'h1000, 16'h1000);
    queue_vec(16'hF000, 16'h1000, 16'hF000);
    queue_vec(16'h0003, 16'h0004, 16'h0000);
    queue_vec(16'h5555, 16'hAAAA, 16'h0F0F);
    queue_vec(16'h0001, 16'h0001, 16'h0001);
    drain_all();

    for (int s = 0; s < 5; s++) begin
      write_min_length(settings[s]);
      if (s == 1 || s == 4) begin
        queue_vec(16'd4096, 16'd0, 16'd0);
        queue_vec(16'd4097, 16'd0, 16'd0);
        queue_vec(16'd1, 16'd0, 16'd0);
        queue_vec(16'd2, 16'd0, 16'd0);
      end
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = mode[m][0];
        recv_stall_pct = mode[m][1];
        if (s == 0 && m == 0) hold_off = 200;
        queue_random(90);
        drain_all();
      end
    end
    send_pause = 1'b1;
    queue_random(40);
    repeat (20) @(posedge clk);
    send_pause = 1'b0;
    drain_all();

    if (errors == 0 && expected_units.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
